[rtl/gbn_pkg.sv]
`default_nettype none
package gbn_pkg;

  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned MAX_WINDOW     = 32;
  localparam int unsigned RESULT_LIMIT   = 32;
  localparam int unsigned WIN_CAP        = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW
                                                                       : RESULT_LIMIT;

  localparam int unsigned WS_W      = 6;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned TOT_W     = 16;
  localparam int unsigned ACK_W     = 16;
  localparam int unsigned FIDX_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CNT_W     = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd2;

  localparam logic [WS_W-1:0]  WS_RESET  = 6'd4;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;
  localparam logic [TOT_W-1:0] TOT_RESET = 16'd1;

  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  typedef struct packed {
    logic [WS_W-1:0]  window_size;
    logic [TMO_W-1:0] timeout_ticks;
    logic [TOT_W-1:0] total_frames;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic emit_retx;
    logic emit_send;
    logic emit_none;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic retx_go;
    logic retx_more;
    logic send_now;
    logic send_after_retx;
    logic send_more;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/gbn_cfg_if.sv]
`default_nettype none
interface gbn_cfg_if;
  import gbn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/gbn_in_if.sv]
`default_nettype none
interface gbn_in_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [ACK_W-1:0] ack_number;
  logic             ack_corrupt;
  modport source(output valid, op, ack_number, ack_corrupt, input ready);
  modport sink(input valid, op, ack_number, ack_corrupt, output ready);
endinterface
`default_nettype wire

[rtl/gbn_out_if.sv]
`default_nettype none
interface gbn_out_if;
  import gbn_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FIDX_W-1:0] frame_index;
  logic              last;
  logic              done_res;
  modport source(output valid, kind, frame_index, last, done_res, input ready);
  modport sink(input valid, kind, frame_index, last, done_res, output ready);
endinterface
`default_nettype wire

[rtl/gbn_cfg_regs.sv]
`default_nettype none
module gbn_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  gbn_cfg_if.sink       cfg_ch,
  output gbn_pkg::cfg_t cfg
);
  import gbn_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size   <= WS_RESET;
      cfg_r.timeout_ticks <= TMO_RESET;
      cfg_r.total_frames  <= TOT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WINDOW_SIZE:   cfg_r.window_size   <= cfg_ch.data[WS_W-1:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_ch.data[TMO_W-1:0];
        REG_TOTAL_FRAMES:  cfg_r.total_frames  <= cfg_ch.data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/gbn_ctrl.sv]
`default_nettype none
module gbn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gbn_pkg::dp_sts_t sts,
  output gbn_pkg::dp_cmd_t cmd
);
  import gbn_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_ROUTE = 6'b000100,
    ST_RETX  = 6'b001000,
    ST_SEND  = 6'b010000,
    ST_NONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (sts.retx_go) state_nxt = ST_RETX;
        else if (sts.send_now) state_nxt = ST_SEND;
        else state_nxt = ST_NONE;
      end
      ST_RETX: begin
        if (sts.out_free) begin
          cmd.emit_retx = 1'b1;
          cmd.last      = !sts.retx_more && !sts.send_after_retx;
          if (sts.retx_more) state_nxt = ST_RETX;
          else if (sts.send_after_retx) state_nxt = ST_SEND;
          else state_nxt = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.emit_send = 1'b1;
          cmd.last      = !sts.send_more;
          state_nxt     = sts.send_more ? ST_SEND : ST_IDLE;
        end
      end
      ST_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

[rtl/gbn_dp.sv]
`default_nettype none
module gbn_dp #(
  parameter int unsigned INDEX_BITS = gbn_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gbn_pkg::cfg_t               cfg,
  input  gbn_pkg::dp_cmd_t            cmd,
  output gbn_pkg::dp_sts_t            sts,
  input  logic                        in_op,
  input  logic [gbn_pkg::ACK_W-1:0]   in_ack_number,
  input  logic                        in_ack_corrupt,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [gbn_pkg::KIND_W-1:0]  out_kind,
  output logic [gbn_pkg::FIDX_W-1:0]  out_frame_index,
  output logic                        out_last,
  output logic                        out_done_res
);
  import gbn_pkg::*;

  localparam int unsigned IW = INDEX_BITS;
  localparam int unsigned CW = (IW > ACK_W) ? IW : ACK_W;
  localparam logic [WS_W-1:0]  CAP_N   = WS_W'(WIN_CAP);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(RESULT_LIMIT);

  // latched item
  logic             op_r;
  logic [ACK_W-1:0] ack_r;
  logic             corrupt_r;

  // window state
  logic [IW-1:0]        base_r;
  logic [IW-1:0]        next_r;
  logic                 running_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // burst bookkeeping
  logic [IW-1:0]    cur_r;
  logic [CNT_W-1:0] cnt_r;
  logic             retx_pend_r;

  // output register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [FIDX_W-1:0] out_idx_r;
  logic              out_last_r;
  logic              out_done_r;

  logic [CW-1:0]        tot_cw, mask_cw, ack_cw, base_cw, next_cw;
  logic [IW-1:0]        total_i;
  logic [WS_W-1:0]      win_n;
  logic [IW:0]          base_plus_n, next_p1, cur_p1;
  logic [CNT_W-1:0]     cnt_p1;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [TMO_W-1:0]     tmo_lim;
  logic                 active, expired, ack_ok;
  logic                 cnt_room, cnt_room_p1;
  logic                 send_ok_next, send_ok_next_p1;
  logic [CW-1:0]        idx_cw;
  logic                 emit;

  always_comb begin
    tot_cw  = CW'(cfg.total_frames);
    mask_cw = CW'({IW{1'b1}});
    total_i = (tot_cw > mask_cw) ? mask_cw[IW-1:0] : tot_cw[IW-1:0];

    if (cfg.window_size == '0) win_n = WS_W'(1);
    else if (cfg.window_size > CAP_N) win_n = CAP_N;
    else win_n = cfg.window_size;

    active      = base_r < total_i;
    base_plus_n = {1'b0, base_r} + (IW+1)'(win_n);
    next_p1     = {1'b0, next_r} + (IW+1)'(1);
    cur_p1      = {1'b0, cur_r} + (IW+1)'(1);
    cnt_p1      = cnt_r + CNT_W'(1);
    cnt_room    = cnt_r < CNT_LIM;
    cnt_room_p1 = cnt_p1 < CNT_LIM;

    elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + ELAPSED_W'(1);
    tmo_lim     = (cfg.timeout_ticks == '0) ? TMO_W'(1) : cfg.timeout_ticks;
    expired     = elapsed_inc >= tmo_lim;

    ack_cw  = CW'(ack_r);
    base_cw = CW'(base_r);
    next_cw = CW'(next_r);
    ack_ok  = !corrupt_r && (ack_cw > base_cw) && (ack_cw <= next_cw);

    // base is settled once the item has been evaluated
    send_ok_next    = active && (next_r < total_i) && ({1'b0, next_r} < base_plus_n);
    send_ok_next_p1 = active && (next_p1 < {1'b0, total_i}) && (next_p1 < base_plus_n);

    sts.out_free        = !out_valid_r || out_ready;
    sts.retx_go         = retx_pend_r;
    sts.retx_more       = (cur_p1 < {1'b0, next_r}) && cnt_room_p1;
    sts.send_now        = send_ok_next && cnt_room;
    sts.send_after_retx = send_ok_next && cnt_room_p1;
    sts.send_more       = send_ok_next_p1 && cnt_room_p1;

    idx_cw = cmd.emit_retx ? CW'(cur_r) : CW'(next_r);
    emit   = cmd.emit_retx || cmd.emit_send || cmd.emit_none;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_op;
      ack_r     <= in_ack_number;
      corrupt_r <= in_ack_corrupt;
    end
    if (cmd.eval) begin
      cur_r <= base_r;
      cnt_r <= '0;
    end else if (cmd.emit_retx || cmd.emit_send) begin
      cnt_r <= cnt_p1;
      if (cmd.emit_retx) cur_r <= cur_p1[IW-1:0];
    end
    if (emit) begin
      out_kind_r <= cmd.emit_retx ? KIND_RETX : (cmd.emit_send ? KIND_SEND : KIND_NONE);
      out_idx_r  <= cmd.emit_none ? '0 : idx_cw[FIDX_W-1:0];
      out_last_r <= cmd.last;
      out_done_r <= !active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      next_r      <= '0;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      retx_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cmd.eval) begin
        retx_pend_r <= 1'b0;
        if (active) begin
          if (!op_r) begin
            if (running_r) begin
              elapsed_r   <= expired ? '0 : elapsed_inc;
              retx_pend_r <= expired && (base_r < next_r);
            end
          end else if (ack_ok) begin
            base_r <= ack_cw[IW-1:0];
            if (ack_cw == next_cw) running_r <= 1'b0;
            else elapsed_r <= '0;
          end
        end
      end

      if (cmd.emit_send) begin
        // first frame of an empty window starts the timer
        if (base_r == next_r) begin
          running_r <= 1'b1;
          elapsed_r <= '0;
        end
        next_r <= next_p1[IW-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_frame_index = out_idx_r;
  assign out_last        = out_last_r;
  assign out_done_res    = out_done_r;

endmodule
`default_nettype wire

[rtl/go_back_n_sender_window_top.sv]
// Channel   Role     Payload                               Handshake
// cfg_ch    sink     index, data                           valid/ready (ready always high)
// in_ch     sink     op, ack_number, ack_corrupt           valid/ready
// out_ch    source   kind, frame_index, last, done_res     valid/ready
//
// One item at a time: accept, evaluate, route, then one result per cycle while out_ch
// does not stall; the burst is paced by the single output register.
// Reset restores window state to zero, timer stopped, registers to defaults.
// Output stalls hold the result and pause the burst; in_ch stays low until the last
// result of the item has been loaded into the output register.
`default_nettype none
module go_back_n_sender_window_top #(
  parameter int unsigned INDEX_BITS = gbn_pkg::INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gbn_cfg_if.sink    cfg_ch,
  gbn_in_if.sink     in_ch,
  gbn_out_if.source  out_ch
);
  import gbn_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  gbn_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_ch.op),
    .in_ack_number   (in_ch.ack_number),
    .in_ack_corrupt  (in_ch.ack_corrupt),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_frame_index (out_ch.frame_index),
    .out_last        (out_ch.last),
    .out_done_res    (out_ch.done_res)
  );

endmodule
`default_nettype wire

[rtl/gbn_chk.sv]
`default_nettype none
module gbn_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gbn_pkg::KIND_W-1:0] out_kind,
  input logic [gbn_pkg::FIDX_W-1:0] out_frame_index,
  input logic                       out_last,
  input logic                       out_done_res
);
  import gbn_pkg::*;

  // one item in flight: no second item right behind the first
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // while a burst is mid-way, the input side stays closed
  a_burst_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open during a result burst");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_last)
    else $error("idle result not marked last");

  // a finished transfer issues no frames
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_kind == KIND_NONE)
    else $error("frame issued after transfer complete");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_index) && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind go_back_n_sender_window_top gbn_chk u_gbn_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_frame_index (out_ch.frame_index),
  .out_last        (out_ch.last),
  .out_done_res    (out_ch.done_res)
);
`default_nettype wire
